// File: design/free_list_pool_with_mark_sweep_defines.svh
// Assertion macros shared by the slot pool design files.
`ifndef FREE_LIST_POOL_WITH_MARK_SWEEP_DEFINES_SVH
`define FREE_LIST_POOL_WITH_MARK_SWEEP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define FLMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define FLMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/flms_pkg.sv
// Types, codes and sizes shared by the slot pool modules.
package flms_pkg;

  // Pool geometry. A pointer carries one extra bit so that POOL_DEPTH means no slot.
  localparam int POOL_DEPTH = 1024;
  localparam int SLOT_W     = $clog2(POOL_DEPTH);
  localparam int PTR_W      = SLOT_W + 1;
  localparam logic [PTR_W-1:0] NO_SLOT = PTR_W'(POOL_DEPTH);

  // Configuration register width and reset value.
  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] POOL_SIZE_RST = 11'd1024;

  // APB port sizes.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Command queue depth; must be a power of two.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  // Operation codes of the input word.
  localparam logic [2:0] OP_INIT    = 3'd0;
  localparam logic [2:0] OP_ALLOC   = 3'd1;
  localparam logic [2:0] OP_FREE    = 3'd2;
  localparam logic [2:0] OP_MARK    = 3'd3;
  localparam logic [2:0] OP_COLLECT = 3'd4;

  // Status codes of the result word.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Command kinds after classification.
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_INIT    = 3'd0;
  localparam kind_t KIND_ALLOC   = 3'd1;
  localparam kind_t KIND_FREE    = 3'd2;
  localparam kind_t KIND_MARK    = 3'd3;
  localparam kind_t KIND_COLLECT = 3'd4;
  localparam kind_t KIND_NOP     = 3'd5;

  typedef struct packed {
    logic [2:0]        op;
    logic [SLOT_W-1:0] slot_index;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    logic [1:0]        status;
    logic [PTR_W-1:0]  reclaimed_count;
  } out_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

endpackage

// File: design/flms_front.sv
// Front end: accepts input words and classifies them into commands.
module flms_front (
  input  logic               start,
  input  flms_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               busy,
  output logic               q_push,
  output flms_pkg::cmd_t     q_cmd
);
  import flms_pkg::*;

  // Hold off new words while the queue has no room.
  assign busy   = q_full;
  assign q_push = start && !q_full;

  // Map the operation code onto a command kind; unknown codes become no-ops.
  always_comb begin
    q_cmd.slot = in_data.slot_index;
    unique case (in_data.op)
      OP_INIT:    q_cmd.kind = KIND_INIT;
      OP_ALLOC:   q_cmd.kind = KIND_ALLOC;
      OP_FREE:    q_cmd.kind = KIND_FREE;
      OP_MARK:    q_cmd.kind = KIND_MARK;
      OP_COLLECT: q_cmd.kind = KIND_COLLECT;
      default:    q_cmd.kind = KIND_NOP;
    endcase
  end

endmodule

// File: design/flms_cmdq.sv
// Short command queue between the front end and the execution engine.
module flms_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  flms_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output flms_pkg::cmd_t pop_cmd,
  output logic           valid
);
  import flms_pkg::*;

  cmd_t               entry_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_AW:0]   fill_r, fill_nxt;

  assign full    = (fill_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign valid   = (fill_r != '0);
  assign pop_cmd = entry_r[rd_ptr_r];

  // Pointers wrap naturally because the depth is a power of two.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + CMDQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + CMDQ_AW'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + (CMDQ_AW+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (CMDQ_AW+1)'(1);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: design/flms_back.sv
// Execution engine: next-pointer and mark memories, free list head, init and collect walks.
module flms_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [flms_pkg::CFG_W-1:0]  pool_size,
  input  flms_pkg::cmd_t              cmd,
  input  logic                        cmd_valid,
  output logic                        cmd_pop,
  output logic                        out_strobe,
  output flms_pkg::out_item_t         out_data
);
  import flms_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_MWALK = 3'd3;
  localparam logic [2:0] S_MNEXT = 3'd4;
  localparam logic [2:0] S_SRD   = 3'd5;
  localparam logic [2:0] S_SWR   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  active_r, active_nxt;
  logic [PTR_W-1:0]  cnt_r, cnt_nxt;
  logic [PTR_W-1:0]  walk_r, walk_nxt;
  logic [PTR_W-1:0]  count_r, count_nxt;
  logic [SLOT_W-1:0] gslot_r, gslot_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  out_item_t         out_data_r, out_data_nxt;

  // Next-pointer memory ports.
  logic [PTR_W-1:0]  next_mem [POOL_DEPTH];
  logic              nw_en;
  logic [SLOT_W-1:0] nw_addr;
  logic [PTR_W-1:0]  nw_data;
  logic [SLOT_W-1:0] nr_addr;
  logic [PTR_W-1:0]  nr_data_r;

  // Mark memory ports.
  logic              mark_mem [POOL_DEPTH];
  logic              mw_en;
  logic [SLOT_W-1:0] mw_addr;
  logic              mw_data;
  logic [SLOT_W-1:0] mr_addr;
  logic              mr_data_r;

  logic [PTR_W-1:0]  init_n;
  logic [PTR_W-1:0]  slot_ext;
  logic              slot_ok;
  logic [PTR_W-1:0]  cnt_inc;

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // Pool size for init, capped at the pool depth.
  assign init_n   = (32'(pool_size) > 32'(POOL_DEPTH)) ? NO_SLOT : PTR_W'(pool_size);
  assign slot_ext = {1'b0, cmd.slot};
  assign slot_ok  = (slot_ext < active_r);
  assign cnt_inc  = cnt_r + PTR_W'(1);

  // Sequencer for all commands.
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    active_nxt     = active_r;
    cnt_nxt        = cnt_r;
    walk_nxt       = walk_r;
    count_nxt      = count_r;
    gslot_nxt      = gslot_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = '0;
    cmd_pop        = 1'b0;
    nw_en          = 1'b0;
    nw_addr        = cnt_r[SLOT_W-1:0];
    nw_data        = head_r;
    nr_addr        = head_r[SLOT_W-1:0];
    mw_en          = 1'b0;
    mw_addr        = cnt_r[SLOT_W-1:0];
    mw_data        = 1'b0;
    mr_addr        = cnt_r[SLOT_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            KIND_INIT: begin
              active_nxt = init_n;
              head_nxt   = (init_n != '0) ? '0 : NO_SLOT;
              cnt_nxt    = '0;
              state_nxt  = S_INIT;
            end
            KIND_ALLOC: begin
              // The head's link is read now and used in the next cycle.
              if (head_r < active_r) begin
                gslot_nxt = head_r[SLOT_W-1:0];
                state_nxt = S_ALLOC;
              end else begin
                head_nxt            = NO_SLOT;
                out_strobe_nxt      = 1'b1;
                out_data_nxt.status = ST_EMPTY;
              end
            end
            KIND_FREE: begin
              out_strobe_nxt = 1'b1;
              if (slot_ok) begin
                nw_en    = 1'b1;
                nw_addr  = cmd.slot;
                nw_data  = head_r;
                head_nxt = slot_ext;
              end else begin
                out_data_nxt.status = ST_RANGE;
              end
            end
            KIND_MARK: begin
              out_strobe_nxt = 1'b1;
              if (slot_ok) begin
                mw_en   = 1'b1;
                mw_addr = cmd.slot;
                mw_data = 1'b1;
              end else begin
                out_data_nxt.status = ST_RANGE;
              end
            end
            KIND_COLLECT: begin
              walk_nxt  = head_r;
              cnt_nxt   = '0;
              count_nxt = '0;
              state_nxt = S_MWALK;
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC: begin
        // A stale link past the active pool ends the list.
        head_nxt                  = (nr_data_r < active_r) ? nr_data_r : NO_SLOT;
        out_strobe_nxt            = 1'b1;
        out_data_nxt.granted_slot = gslot_r;
        state_nxt                 = S_IDLE;
      end
      S_INIT: begin
        // Clear every mark and chain the active slots in ascending order.
        mw_en = 1'b1;
        if (cnt_r < active_r) begin
          nw_en   = 1'b1;
          nw_data = (cnt_inc < active_r) ? cnt_inc : NO_SLOT;
        end
        if (cnt_r == PTR_W'(POOL_DEPTH - 1)) begin
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      S_MWALK: begin
        // Mark the current free slot and fetch its link; the step count bounds cycles.
        if ((walk_r < active_r) && (cnt_r < active_r)) begin
          mw_en     = 1'b1;
          mw_addr   = walk_r[SLOT_W-1:0];
          mw_data   = 1'b1;
          nr_addr   = walk_r[SLOT_W-1:0];
          state_nxt = S_MNEXT;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_SRD;
        end
      end
      S_MNEXT: begin
        walk_nxt  = nr_data_r;
        cnt_nxt   = cnt_inc;
        state_nxt = S_MWALK;
      end
      S_SRD: begin
        // Read the mark of the next slot in the sweep.
        if (cnt_r < active_r) begin
          state_nxt = S_SWR;
        end else begin
          out_strobe_nxt               = 1'b1;
          out_data_nxt.reclaimed_count = count_r;
          state_nxt                    = S_IDLE;
        end
      end
      S_SWR: begin
        // Push an unmarked slot and clear its mark.
        mw_en = 1'b1;
        if (!mr_data_r) begin
          nw_en     = 1'b1;
          head_nxt  = cnt_r;
          count_nxt = count_r + PTR_W'(1);
        end
        cnt_nxt   = cnt_inc;
        state_nxt = S_SRD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= NO_SLOT;
      active_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      active_r     <= active_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    walk_r     <= walk_nxt;
    count_r    <= count_nxt;
    gslot_r    <= gslot_nxt;
    out_data_r <= out_data_nxt;
  end

  // Next-pointer memory with registered read.
  always_ff @(posedge clk) begin
    if (nw_en) begin
      next_mem[nw_addr] <= nw_data;
    end
    nr_data_r <= next_mem[nr_addr];
  end

  // Mark memory with registered read.
  always_ff @(posedge clk) begin
    if (mw_en) begin
      mark_mem[mw_addr] <= mw_data;
    end
    mr_data_r <= mark_mem[mr_addr];
  end

endmodule

// File: design/free_list_pool_with_mark_sweep.sv
// Top level of the slot pool: APB register, front end, command queue and engine.
//
//   channel  | handshake                    | word
//   ---------+------------------------------+-----------------------------------
//   input    | start, busy                  | in_data (op, slot_index)
//   result   | out_strobe, one cycle        | out_data (granted_slot, status,
//            |                              |   reclaimed_count)
//   config   | psel, penable, pwrite, pready| paddr, pwdata, prdata (pool_size)
//
// Free, mark and unknown ops are handled in the idle state alone; alloc also
// passes through S_ALLOC for the registered next-pointer read. out_strobe is
// registered from the state that ends each op. Init walks every slot of the
// pool in S_INIT; collect walks the free list in S_MWALK and S_MNEXT, then
// sweeps the active slots in S_SRD and S_SWR. busy is high while the two-entry
// command queue is full. Reset clears control state; init clears the mark bits
// before any use. The result receiver cannot stall.
`include "free_list_pool_with_mark_sweep_defines.svh"

module free_list_pool_with_mark_sweep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  flms_pkg::in_item_t            in_data,
  output logic                          out_strobe,
  output flms_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [flms_pkg::PADDR_W-1:0]  paddr,
  input  logic [flms_pkg::PDATA_W-1:0]  pwdata,
  output logic [flms_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import flms_pkg::*;

  localparam logic REG_POOL_SIZE = 1'b0;

  logic [CFG_W-1:0] pool_size_r, pool_size_nxt;
  logic             cfg_write;
  logic             q_full;
  logic             q_push;
  cmd_t             q_cmd;
  logic             q_pop;
  logic             q_valid;
  cmd_t             q_head;

  // Configuration register; the register index is the word address.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    pool_size_nxt = pool_size_r;
    if (cfg_write && (paddr[2] == REG_POOL_SIZE)) begin
      pool_size_nxt = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= POOL_SIZE_RST;
    end else begin
      pool_size_r <= pool_size_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_POOL_SIZE) ? PDATA_W'(pool_size_r) : '0;

  flms_front u_front (
    .start   (start),
    .in_data (in_data),
    .q_full  (q_full),
    .busy    (busy),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  flms_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_head),
    .valid    (q_valid)
  );

  flms_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pool_size  (pool_size_r),
    .cmd        (q_head),
    .cmd_valid  (q_valid),
    .cmd_pop    (q_pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  // The engine only takes a command that the queue holds.
  `FLMS_ASSERT_IMP(a_pop_valid, q_pop, q_valid, "command popped from an empty queue")
  // An accepted word is waiting in the queue in the following cycle.
  `FLMS_ASSERT_NXT(a_accept_queued, start && !busy, q_valid, "accepted word lost")
  // A failing status carries no slot and no count.
  `FLMS_ASSERT_IMP(a_err_fields, out_strobe && (out_data.status != ST_OK), (out_data.granted_slot == '0) && (out_data.reclaimed_count == '0), "error result with nonzero fields")

endmodule

// File: sim/free_list_pool_with_mark_sweep_tb.sv
// Self-checking testbench for the free-list slot pool with mark-and-sweep collection.
module free_list_pool_with_mark_sweep_tb;
  import flms_pkg::*;

  // Ops 5 to 7 are unused and must answer an all-zero word.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // Register map: pool_size is register 0.
  localparam logic [PADDR_W-1:0] REG_POOL_SIZE = '0;

  localparam int RANDOM_WORDS  = 1150;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;

  typedef struct {
    logic              cfg_wr;
    logic [PDATA_W-1:0] cfg_val;
    in_item_t          word;
    logic              typed;
    out_item_t         want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_item_t           in_data;
  logic               out_strobe;
  out_item_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Shadow copy of the pool: link store, mark bits, list head and sizes.
  logic [PTR_W-1:0] link_mem [POOL_DEPTH];
  logic             mark_mem [POOL_DEPTH];
  logic [PTR_W-1:0] head_ptr;
  int unsigned      live_size;
  logic [CFG_W-1:0] size_reg;

  out_item_t        pending_results [$];
  logic [SLOT_W-1:0] held_slots [$];
  dir_row_t         dir_rows [$];
  out_item_t        result_want;
  int               mismatches = 0;
  int               words_sent = 0;
  int               burst_left = 0;

  free_list_pool_with_mark_sweep dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #4 clk = ~clk;

  // Apply one word to the shadow pool and return the result word it should produce.
  function automatic out_item_t pool_predict(in_item_t w);
    out_item_t   r;
    int unsigned n;
    int unsigned p;
    int unsigned steps;
    int unsigned cnt;
    r = '0;
    case (w.op)
      OP_INIT: begin
        n = (size_reg > POOL_DEPTH) ? POOL_DEPTH : size_reg;
        live_size = n;
        for (int i = 0; i < n; i++) link_mem[i] = (i + 1 < n) ? PTR_W'(i + 1) : NO_SLOT;
        head_ptr = (n > 0) ? '0 : NO_SLOT;
        foreach (mark_mem[i]) mark_mem[i] = 1'b0;
      end
      OP_ALLOC: begin
        if (head_ptr < live_size) begin
          r.granted_slot = head_ptr[SLOT_W-1:0];
          head_ptr = link_mem[head_ptr];
          // A link that points outside the live pool ends the list.
          if (head_ptr >= live_size) head_ptr = NO_SLOT;
        end else begin
          head_ptr = NO_SLOT;
          r.status = ST_EMPTY;
        end
      end
      OP_FREE: begin
        if (w.slot_index < live_size) begin
          link_mem[w.slot_index] = head_ptr;
          head_ptr = PTR_W'(w.slot_index);
        end else begin
          r.status = ST_RANGE;
        end
      end
      OP_MARK: begin
        if (w.slot_index < live_size) mark_mem[w.slot_index] = 1'b1;
        else r.status = ST_RANGE;
      end
      OP_COLLECT: begin
        // Mark the free list, bounded so a cyclic list after a double free ends.
        p = head_ptr;
        steps = 0;
        cnt = 0;
        while (p < live_size && steps < live_size) begin
          mark_mem[p] = 1'b1;
          p = link_mem[p];
          steps++;
        end
        // Sweep in ascending order and push every unmarked slot.
        for (int i = 0; i < live_size; i++) begin
          if (!mark_mem[i]) begin
            link_mem[i] = head_ptr;
            head_ptr = PTR_W'(i);
            cnt++;
          end
        end
        foreach (mark_mem[i]) mark_mem[i] = 1'b0;
        r.reclaimed_count = PTR_W'(cnt);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic dir_row_t dir_row(int cfg_wr, logic [PDATA_W-1:0] cfg_val,
                                       logic [2:0] op, int idx, int typed,
                                       int granted, logic [1:0] status, int count);
    dir_row_t d;
    d.cfg_wr                = (cfg_wr != 0);
    d.cfg_val               = cfg_val;
    d.word.op               = op;
    d.word.slot_index       = SLOT_W'(idx);
    d.typed                 = (typed != 0);
    d.want.granted_slot     = SLOT_W'(granted);
    d.want.status           = status;
    d.want.reclaimed_count  = PTR_W'(count);
    return d;
  endfunction

  // Offer one word until it is taken, then log its expected result and maybe idle.
  task automatic send_word(input in_item_t w, input logic typed, input out_item_t want,
                           output out_item_t predicted);
    int gap;
    start   <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = pool_predict(w);
    pending_results.push_back(typed ? want : predicted);
    words_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Hold the sender off until every expected word has come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write pool_size over the register port, then read it back.
  task automatic write_pool_size(input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_POOL_SIZE;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    size_reg = value[CFG_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CFG_W-1:0] !== size_reg) begin
      $display("%0t: pool_size readback expected %0d, got %0d", $time, size_reg,
               prdata[CFG_W-1:0]);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Compare every result word with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 100)
          $display("%0t: unexpected word: expected none, got granted %0d status %0d count %0d",
                   $time, out_data.granted_slot, out_data.status, out_data.reclaimed_count);
        mismatches++;
      end else begin
        result_want = pending_results.pop_front();
        if (out_data.granted_slot !== result_want.granted_slot ||
            out_data.status !== result_want.status ||
            out_data.reclaimed_count !== result_want.reclaimed_count) begin
          if (mismatches < 100)
            $display("%0t: expected granted %0d status %0d count %0d, got granted %0d status %0d count %0d",
                     $time, result_want.granted_slot, result_want.status,
                     result_want.reclaimed_count, out_data.granted_slot, out_data.status,
                     out_data.reclaimed_count);
          mismatches++;
        end
      end
    end
  end

  // Hard limit in case the block hangs.
  initial begin
    #150_000_000;
    $display("free_list_pool_with_mark_sweep: mismatch");
    $finish;
  end

  initial begin
    in_item_t         w;
    out_item_t        predicted;
    int               pick;
    int               k;
    int               phase_idx;
    int               phase_end;
    int               guard;
    int unsigned      cfg_size;
    logic [PDATA_W-1:0] cfg_word;

    // Shadow state after reset: empty list, no live slots, marks clear.
    foreach (link_mem[i]) link_mem[i] = '0;
    foreach (mark_mem[i]) mark_mem[i] = 1'b0;
    head_ptr  = NO_SLOT;
    live_size = 0;
    size_reg  = POOL_SIZE_RST;

    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Before any init no slot is live: alloc is empty, free and mark are out of range.
    dir_rows.push_back(dir_row(0, 0, OP_ALLOC, 0, 1, 0, ST_EMPTY, 0));
    dir_rows.push_back(dir_row(0, 0, OP_FREE, 0, 1, 0, ST_RANGE, 0));
    dir_rows.push_back(dir_row(0, 0, OP_MARK, 1023, 1, 0, ST_RANGE, 0));
    dir_rows.push_back(dir_row(0, 0, OP_COLLECT, 0, 1, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(0, 0, OP_UNUSED_LO, 1023, 1, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(0, 0, OP_UNUSED_HI, 0, 1, 0, ST_OK, 0));
    // Full pool at the reset size, with a double free that makes the list cyclic.
    dir_rows.push_back(dir_row(0, 0, OP_INIT, 1023, 1, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(0, 0, OP_ALLOC, 0, 1, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(0, 0, OP_ALLOC, 0, 1, 1, ST_OK, 0));
    dir_rows.push_back(dir_row(0, 0, OP_FREE, 1023, 1, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(0, 0, OP_MARK, 1023, 1, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(0, 0, OP_ALLOC, 0, 1, 1023, ST_OK, 0));
    dir_rows.push_back(dir_row(0, 0, OP_FREE, 1023, 1, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(0, 0, OP_FREE, 1023, 1, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(0, 0, OP_COLLECT, 0, 0, 0, ST_OK, 0));
    // A pool size of zero gives an empty pool.
    dir_rows.push_back(dir_row(1, 0, OP_INIT, 0, 1, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(0, 0, OP_ALLOC, 0, 1, 0, ST_EMPTY, 0));
    dir_rows.push_back(dir_row(0, 0, OP_FREE, 0, 1, 0, ST_RANGE, 0));
    dir_rows.push_back(dir_row(0, 0, OP_COLLECT, 0, 1, 0, ST_OK, 0));
    // Single-slot pool: drain it, then free the slot twice.
    dir_rows.push_back(dir_row(1, 1, OP_INIT, 0, 1, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(0, 0, OP_ALLOC, 0, 1, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(0, 0, OP_ALLOC, 0, 1, 0, ST_EMPTY, 0));
    dir_rows.push_back(dir_row(0, 0, OP_FREE, 0, 1, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(0, 0, OP_FREE, 0, 1, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(0, 0, OP_COLLECT, 0, 0, 0, ST_OK, 0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_wr) begin
        wait_drained();
        write_pool_size(dir_rows[i].cfg_val);
      end
      send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want, predicted);
    end

    // Random phases, each under its own pool size and starting with an init.
    phase_idx = 0;
    while (words_sent < RANDOM_WORDS + dir_rows.size()) begin
      case (phase_idx)
        0: cfg_size = 2047;
        1: cfg_size = 0;
        2: cfg_size = 1;
        3: cfg_size = 2;
        4: cfg_size = 1024;
        default: begin
          pick = $urandom_range(0, 19);
          if (pick < 14) cfg_size = $urandom_range(3, 40);
          else if (pick < 17) cfg_size = $urandom_range(41, 300);
          else if (pick < 19) cfg_size = $urandom_range(1025, 2047);
          else cfg_size = 1024;
        end
      endcase
      // Upper data bits are random; only the low bits hold the register.
      cfg_word = ($urandom & 32'hFFFF_F800) | cfg_size;
      wait_drained();
      write_pool_size(cfg_word);
      w.op = OP_INIT;
      w.slot_index = SLOT_W'($urandom);
      send_word(w, 1'b0, '0, predicted);
      held_slots.delete();
      phase_end = words_sent + $urandom_range(50, 100);

      while (words_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        w.op = OP_ALLOC;
        w.slot_index = SLOT_W'($urandom);
        if (pick < 36) begin
          send_word(w, 1'b0, '0, predicted);
          if (predicted.status == ST_OK) held_slots.push_back(predicted.granted_slot);
        end else if (pick < 74) begin
          // Free or mark: mostly a slot the host holds, else any index.
          w.op = (pick < 60) ? OP_FREE : OP_MARK;
          if (held_slots.size() != 0 && $urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, held_slots.size() - 1);
            w.slot_index = held_slots[k];
            if (w.op == OP_FREE) held_slots.delete(k);
          end else if (live_size != 0 && $urandom_range(0, 1) != 0) begin
            w.slot_index = SLOT_W'($urandom_range(0, live_size - 1));
          end
          send_word(w, 1'b0, '0, predicted);
        end else if (pick < 84) begin
          // Host walk: mark most held slots, then collect; unmarked ones are lost.
          foreach (held_slots[j]) begin
            if ($urandom_range(0, 7) != 0) begin
              w.op = OP_MARK;
              w.slot_index = held_slots[j];
              send_word(w, 1'b0, '0, predicted);
            end
          end
          for (k = held_slots.size() - 1; k >= 0; k--)
            if (!mark_mem[held_slots[k]]) held_slots.delete(k);
          w.op = OP_COLLECT;
          w.slot_index = SLOT_W'($urandom);
          send_word(w, 1'b0, '0, predicted);
        end else if (pick < 87) begin
          w.op = OP_INIT;
          send_word(w, 1'b0, '0, predicted);
          held_slots.delete();
        end else begin
          w.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
          send_word(w, 1'b0, '0, predicted);
        end
      end
      phase_idx++;
    end

    // Let the last words come back, within a bound.
    start <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("free_list_pool_with_mark_sweep: match");
    end else begin
      $display("free_list_pool_with_mark_sweep: mismatch");
    end
    $finish;
  end

endmodule
